/* rtl/obpl_pkg.sv */
// shared types and constants for the order book price level block
package obpl_pkg;

    localparam int MAX_ORDERS_DEF  = 64;
    localparam int MAX_SHOWN_DEF   = 10;
    localparam int LEVELS_SHOWN_RST = 10;
    localparam int Q_DEPTH         = 2;

    localparam int PRICE_W  = 20;
    localparam int QTY_W    = 20;
    localparam int ID_W     = 32;
    localparam int CNT_W    = 7;
    localparam int LQTY_W   = 26;
    localparam int RANK_W   = 4;
    localparam int SHOWN_CFG_W = 4;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [LQTY_W-1:0] LQTY_MAX = {LQTY_W{1'b1}};

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_CANCEL = 1'b1
    } op_t;

    typedef enum logic {
        SIDE_BUY  = 1'b0,
        SIDE_SELL = 1'b1
    } side_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_MOD,
        ENG_COMMIT,
        ENG_LEVEL,
        ENG_EMIT
    } eng_state_t;

    typedef struct packed {
        op_t               op;
        side_t             side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [ID_W-1:0]    cid;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    aid;
        logic               side_empty;
        logic [RANK_W-1:0]  rank;
        logic [PRICE_W-1:0] price;
        logic [CNT_W-1:0]   orders;
        logic [LQTY_W-1:0]  quantity;
        logic               last;
    } result_t;

endpackage

/* rtl/order_book_price_levels_top.sv */
// top level of the order book price level block
//
//  port group      dir   beat contents
//  s_axis_*        in    one add or cancel command
//  m_axis_*        out   one price level (or an empty-side marker), tlast on the final one
//  cfg_wr_*        in    levels_shown register write
//
// an item is handled as one store scan for the update, then one scan per level, each
// reading one entry a cycle from the single read port of the order memory; the engine
// stalls while a finished beat waits in the output register for m_axis_tready.
// reset clears the valid bits of both stores; no clearing pass is needed.
// a two-entry command queue lets the input side keep taking beats while the engine works
// or while a finished level waits in the output register for m_axis_tready.
module order_book_price_levels_top
    import obpl_pkg::*;
#(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF,
    parameter int MAX_SHOWN  = MAX_SHOWN_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // price, quantity, cancel_id
    input  logic [1:0]  s_axis_tuser,   // operation, side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // assigned_id, level_rank, level_price,
                                        // level_orders, level_quantity, zero fill
    output logic [2:0]  m_axis_tuser,   // status, side_empty
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data
);

    localparam int SHOWN_W = $clog2(MAX_SHOWN + 1);
    localparam int CMP_W   = SHOWN_W + SHOWN_CFG_W;

    logic [SHOWN_CFG_W-1:0] levels_shown_reg;
    logic [CMP_W-1:0]       cfg_ext;
    logic [SHOWN_W-1:0]     shown_eff;

    cmd_t    f_cmd, q_cmd;
    logic    f_valid, f_ready, q_valid, q_ready;
    logic    r_valid;
    result_t r;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_shown_reg <= SHOWN_CFG_W'(LEVELS_SHOWN_RST);
        end else if (cfg_wr_en) begin
            levels_shown_reg <= cfg_wr_data;
        end
    end

    // clamp shown levels to 1..MAX_SHOWN
    always_comb begin
        cfg_ext = CMP_W'(levels_shown_reg);
        if (levels_shown_reg == '0) begin
            shown_eff = SHOWN_W'(1);
        end else if (cfg_ext > CMP_W'(MAX_SHOWN)) begin
            shown_eff = SHOWN_W'(MAX_SHOWN);
        end else begin
            shown_eff = cfg_ext[SHOWN_W-1:0];
        end
    end

    obpl_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (f_valid),
        .cmd_ready     (f_ready),
        .cmd           (f_cmd)
    );

    obpl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cmd)
    );

    obpl_engine #(
        .MAX_ORDERS (MAX_ORDERS),
        .MAX_SHOWN  (MAX_SHOWN)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .shown     (shown_eff),
        .res_valid (r_valid),
        .res_ready (m_axis_tready),
        .res       (r)
    );

    // pack the result beat
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r.quantity, r.orders, r.price, r.rank, r.aid};
    assign m_axis_tuser  = {r.side_empty, r.status};
    assign m_axis_tlast  = r.last;

endmodule

/* rtl/obpl_front.sv */
// input stage: takes beats from the input stream and decodes them into commands
module obpl_front
    import obpl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic vld_reg, vld_next;
    cmd_t cmd_reg;
    cmd_t dec;
    logic take;

    // decode one beat
    always_comb begin
        dec.op    = op_t'(s_axis_tuser[0]);
        dec.side  = side_t'(s_axis_tuser[1]);
        dec.price = s_axis_tdata[19:0];
        dec.qty   = s_axis_tdata[39:20];
        dec.cid   = s_axis_tdata[71:40];
    end

    assign s_axis_tready = !vld_reg || cmd_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    // holding register valid
    always_comb begin
        if (take) begin
            vld_next = 1'b1;
        end else if (cmd_ready) begin
            vld_next = 1'b0;
        end else begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cmd_reg <= dec;
        end
    end

    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;

endmodule

/* rtl/obpl_queue.sv */
// short command queue between the front and the engine
module obpl_queue
    import obpl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    cmd_t               buf_reg [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_QW'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = buf_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_QW'(Q_DEPTH))
        else $error("queue count out of range");

    // a pop with no push lowers the count by one
    a_count_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop on pop");

    // the entry written is the one read after an empty queue
    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && count_reg == '0) |=> (pop_data == $past(push_data)))
        else $error("queue data mismatch");

endmodule

/* rtl/obpl_engine.sv */
// back part: order store update, level aggregation scans and result register
module obpl_engine
    import obpl_pkg::*;
#(
    parameter int MAX_ORDERS = MAX_ORDERS_DEF,
    parameter int MAX_SHOWN  = MAX_SHOWN_DEF
)(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_SHOWN+1)-1:0] shown,
    output logic                          res_valid,
    input  logic                          res_ready,
    output result_t                       res
);

    localparam int IDX_W   = $clog2(MAX_ORDERS);
    localparam int ADDR_W  = IDX_W + 1;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int SHOWN_W = $clog2(MAX_SHOWN + 1);

    // order memory, both sides, side selects the upper address bit
    logic [ID_W-1:0]    mem_id    [DEPTH];
    logic [PRICE_W-1:0] mem_price [DEPTH];
    logic [QTY_W-1:0]   mem_qty   [DEPTH];
    logic [ID_W-1:0]    rd_id_reg;
    logic [PRICE_W-1:0] rd_price_reg;
    logic [QTY_W-1:0]   rd_qty_reg;

    logic [1:0][MAX_ORDERS-1:0] valid_reg;

    eng_state_t state_reg, state_next;
    cmd_t       cmd_reg;

    logic [IDX_W:0]     scan_idx_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               issuing, scan_done;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;

    logic               slot_found_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               hit_reg;
    status_t            status_reg;
    logic [ID_W-1:0]    aid_reg;
    logic [ID_W-1:0]    next_id_reg;

    logic [SHOWN_W-1:0] rank_reg;
    logic [PRICE_W-1:0] prev_reg;
    logic               best_found_reg;
    logic [PRICE_W-1:0] best_price_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [LQTY_W-1:0]  best_qty_reg;
    logic               other_reg;

    logic               out_valid_reg;
    result_t            out_reg;

    logic               ent_valid, elig, better;
    logic [LQTY_W:0]    qsum;
    logic               out_free, emit_last, emit_fire, wr_en;
    logic [SHOWN_W+RANK_W-1:0] rank_ext;

    assign issuing   = (scan_idx_reg < (IDX_W+1)'(MAX_ORDERS));
    assign scan_done = !issuing && !rd_vld_reg;
    assign rd_addr   = {cmd_reg.side, scan_idx_reg[IDX_W-1:0]};
    assign wr_addr   = {cmd_reg.side, slot_reg};
    assign ent_valid = valid_reg[cmd_reg.side][rd_idx_reg];

    // compare the entry under scan against the running best level
    always_comb begin
        if (cmd_reg.side == SIDE_BUY) begin
            elig   = (rank_reg == '0) || (rd_price_reg < prev_reg);
            better = rd_price_reg > best_price_reg;
        end else begin
            elig   = (rank_reg == '0) || (rd_price_reg > prev_reg);
            better = rd_price_reg < best_price_reg;
        end
        qsum = {1'b0, best_qty_reg} + (LQTY_W+1)'(rd_qty_reg);
    end

    assign out_free  = !out_valid_reg || res_ready;
    assign emit_last = !best_found_reg || !other_reg || ((rank_reg + 1'b1) == shown);
    assign emit_fire = (state_reg == ENG_EMIT) && out_free;
    assign wr_en     = (state_reg == ENG_COMMIT) && (cmd_reg.op == OP_ADD) && slot_found_reg;
    assign cmd_ready = (state_reg == ENG_IDLE);
    assign rank_ext  = {{RANK_W{1'b0}}, rank_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: begin
                if (cmd_valid) state_next = ENG_MOD;
            end
            ENG_MOD: begin
                if (scan_done) state_next = ENG_COMMIT;
            end
            ENG_COMMIT: begin
                state_next = ENG_LEVEL;
            end
            ENG_LEVEL: begin
                if (scan_done) state_next = ENG_EMIT;
            end
            ENG_EMIT: begin
                if (out_free) state_next = emit_last ? ENG_IDLE : ENG_LEVEL;
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_id[wr_addr]    <= next_id_reg;
            mem_price[wr_addr] <= cmd_reg.price;
            mem_qty[wr_addr]   <= cmd_reg.qty;
        end
        rd_id_reg    <= mem_id[rd_addr];
        rd_price_reg <= mem_price[rd_addr];
        rd_qty_reg   <= mem_qty[rd_addr];
    end

    // control state: valid bits, id counter, scan pipe, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            next_id_reg   <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ENG_IDLE || state_reg == ENG_COMMIT || emit_fire) begin
                scan_idx_reg <= '0;
                rd_vld_reg   <= 1'b0;
            end else if (state_reg == ENG_MOD || state_reg == ENG_LEVEL) begin
                rd_vld_reg <= issuing;
                if (issuing) scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            // cancel clears every matching entry
            if (state_reg == ENG_MOD && rd_vld_reg && cmd_reg.op == OP_CANCEL &&
                ent_valid && rd_id_reg == cmd_reg.cid) begin
                valid_reg[cmd_reg.side][rd_idx_reg] <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[cmd_reg.side][slot_reg] <= 1'b1;
                next_id_reg <= next_id_reg + 1'b1;
            end
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and level working registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        case (state_reg)
            ENG_IDLE: begin
                cmd_reg        <= cmd;
                slot_found_reg <= 1'b0;
                slot_reg       <= '0;
                hit_reg        <= 1'b0;
            end
            ENG_MOD: begin
                if (rd_vld_reg && cmd_reg.op == OP_ADD && !ent_valid && !slot_found_reg) begin
                    slot_found_reg <= 1'b1;
                    slot_reg       <= rd_idx_reg;
                end
                if (rd_vld_reg && cmd_reg.op == OP_CANCEL && ent_valid &&
                    rd_id_reg == cmd_reg.cid) begin
                    hit_reg <= 1'b1;
                end
            end
            ENG_COMMIT: begin
                aid_reg        <= '0;
                rank_reg       <= '0;
                prev_reg       <= '0;
                best_found_reg <= 1'b0;
                other_reg      <= 1'b0;
                if (cmd_reg.op == OP_ADD) begin
                    if (slot_found_reg) begin
                        status_reg <= ST_DONE;
                        aid_reg    <= next_id_reg;
                    end else begin
                        status_reg <= ST_FULL;
                    end
                end else begin
                    status_reg <= hit_reg ? ST_DONE : ST_NOT_FOUND;
                end
            end
            ENG_LEVEL: begin
                if (rd_vld_reg && ent_valid && elig) begin
                    if (!best_found_reg || better) begin
                        other_reg      <= other_reg | best_found_reg;
                        best_found_reg <= 1'b1;
                        best_price_reg <= rd_price_reg;
                        best_cnt_reg   <= CNT_W'(1);
                        best_qty_reg   <= LQTY_W'(rd_qty_reg);
                    end else if (rd_price_reg == best_price_reg) begin
                        if (best_cnt_reg != CNT_MAX) best_cnt_reg <= best_cnt_reg + 1'b1;
                        best_qty_reg <= qsum[LQTY_W] ? LQTY_MAX : qsum[LQTY_W-1:0];
                    end else begin
                        other_reg <= 1'b1;
                    end
                end
            end
            ENG_EMIT: begin
                if (out_free) begin
                    prev_reg       <= best_price_reg;
                    rank_reg       <= rank_reg + 1'b1;
                    best_found_reg <= 1'b0;
                    other_reg      <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            out_reg.status     <= status_reg;
            out_reg.aid        <= aid_reg;
            out_reg.side_empty <= !best_found_reg;
            out_reg.rank       <= rank_ext[RANK_W-1:0];
            out_reg.price      <= best_found_reg ? best_price_reg : '0;
            out_reg.orders     <= best_found_reg ? best_cnt_reg : '0;
            out_reg.quantity   <= best_found_reg ? best_qty_reg : '0;
            out_reg.last       <= emit_last;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // the id counter only ever steps by one
    a_id_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (next_id_reg != $past(next_id_reg)) |-> (next_id_reg == $past(next_id_reg) + 1'b1))
        else $error("order id counter jumped");

    // a new result only follows an emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ENG_EMIT))
        else $error("result raised outside emit");

    // a full-side status only comes from an add
    a_full_add: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ENG_EMIT && status_reg == ST_FULL) |-> (cmd_reg.op == OP_ADD))
        else $error("full status on a cancel");

    // an empty-side result is always the last of its item
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.side_empty) |-> out_reg.last)
        else $error("empty result not marked last");

endmodule

/* bench/tb_order_book_price_levels_top.sv */
// self-checking testbench for the order book price level block
module tb_order_book_price_levels_top;
    import obpl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BOOK_DEPTH = MAX_ORDERS_DEF;
    localparam int PHASES     = 5;
    localparam int PHASE_LEN  = 71;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;

    order_book_price_levels_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // book mirror and register copy
    logic              book_valid [2][BOOK_DEPTH];
    logic [ID_W-1:0]   book_id    [2][BOOK_DEPTH];
    logic [PRICE_W-1:0] book_price [2][BOOK_DEPTH];
    logic [QTY_W-1:0]  book_qty   [2][BOOK_DEPTH];
    logic [ID_W-1:0]   next_id = '0;
    logic [3:0]        shown_reg = 4'(LEVELS_SHOWN_RST);

    cmd_t    pending_cmds[$];
    result_t expected_levels[$];
    int      tx_idle_pct = 12;
    int      rx_idle_pct = 72;
    int      errors = 0;
    logic    s_fire = 1'b0;
    int      gen_ids = 0;

    // append one command to the pending list
    task automatic queue_cmd(cmd_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // apply one command to the mirror and queue the level beats it should produce
    task automatic predict_levels(cmd_t c);
        int s, slot, n, k, best, cnt, lim;
        logic hit;
        status_t st;
        logic [ID_W-1:0] aid;
        logic [PRICE_W-1:0] lp [BOOK_DEPTH];
        logic [CNT_W-1:0]   lo [BOOK_DEPTH];
        logic [LQTY_W-1:0]  lq [BOOK_DEPTH];
        logic               lu [BOOK_DEPTH];
        logic [LQTY_W:0]    sum;
        result_t r;
        s = (c.side == SIDE_SELL) ? 1 : 0;
        st = ST_DONE;
        aid = '0;
        if (c.op == OP_ADD) begin
            slot = -1;
            for (int i = 0; i < BOOK_DEPTH; i++)
                if (!book_valid[s][i] && slot < 0) slot = i;
            if (slot < 0) begin
                st = ST_FULL;
            end else begin
                book_valid[s][slot] = 1'b1;
                book_id[s][slot] = next_id;
                book_price[s][slot] = c.price;
                book_qty[s][slot] = c.qty;
                aid = next_id;
                next_id = next_id + 1'b1;
            end
        end else begin
            hit = 1'b0;
            for (int i = 0; i < BOOK_DEPTH; i++)
                if (book_valid[s][i] && book_id[s][i] == c.cid) begin
                    book_valid[s][i] = 1'b0;
                    hit = 1'b1;
                end
            if (!hit) st = ST_NOT_FOUND;
        end
        // group into levels in store order
        n = 0;
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            if (book_valid[s][i]) begin
                k = n;
                for (int j = 0; j < n; j++)
                    if (k == n && lp[j] == book_price[s][i]) k = j;
                if (k == n) begin
                    lp[n] = book_price[s][i];
                    lo[n] = '0;
                    lq[n] = '0;
                    lu[n] = 1'b0;
                    n++;
                end
                if (lo[k] != CNT_MAX) lo[k] = lo[k] + 1'b1;
                sum = lq[k] + book_qty[s][i];
                lq[k] = (sum > LQTY_MAX) ? LQTY_MAX : sum[LQTY_W-1:0];
            end
        end
        lim = (shown_reg == 0) ? 1 : (shown_reg > MAX_SHOWN_DEF) ? MAX_SHOWN_DEF : shown_reg;
        r.status = st;
        r.aid = aid;
        if (n == 0) begin
            r.side_empty = 1'b1;
            r.rank = '0;
            r.price = '0;
            r.orders = '0;
            r.quantity = '0;
            r.last = 1'b1;
            expected_levels = {expected_levels, r};
        end else begin
            cnt = (n < lim) ? n : lim;
            for (int rk = 0; rk < cnt; rk++) begin
                best = -1;
                for (int j = 0; j < n; j++)
                    if (!lu[j] && (best < 0 ||
                        (s == 0 ? lp[j] > lp[best] : lp[j] < lp[best])))
                        best = j;
                lu[best] = 1'b1;
                r.side_empty = 1'b0;
                r.rank = RANK_W'(rk);
                r.price = lp[best];
                r.orders = lo[best];
                r.quantity = lq[best];
                r.last = (rk == cnt - 1);
                expected_levels = {expected_levels, r};
            end
        end
    endtask

    function automatic cmd_t make_cmd(op_t op, side_t sd, int unsigned pr, int unsigned q,
                                      int unsigned id);
        cmd_t c;
        c.op = op;
        c.side = sd;
        c.price = PRICE_W'(pr);
        c.qty = QTY_W'(q);
        c.cid = id;
        return c;
    endfunction

    // random command: clustered prices so levels share orders, some full-range values
    function automatic cmd_t random_cmd(int add_pct, int sell_pct);
        cmd_t c;
        c.op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_CANCEL;
        c.side = ($urandom_range(99) < sell_pct) ? SIDE_SELL : SIDE_BUY;
        c.price = ($urandom_range(3) == 0) ? PRICE_W'($urandom)
                                           : PRICE_W'(1000 + $urandom_range(14));
        c.qty = ($urandom_range(19) == 0) ? '0 : QTY_W'($urandom_range(1, 1048575));
        if ($urandom_range(9) == 0 || gen_ids == 0)
            c.cid = $urandom;
        else
            c.cid = $urandom_range(gen_ids - 1);
        return c;
    endfunction

    // input handshake record and prediction on acceptance
    always @(posedge aclk) begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            predict_levels(cmd_t'({s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[19:0],
                                   s_axis_tdata[39:20], s_axis_tdata[71:40]}));
    end

    // command driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tdata <= {pending_cmds[0].cid, pending_cmds[0].qty,
                                 pending_cmds[0].price};
                s_axis_tuser <= {pending_cmds[0].side, pending_cmds[0].op};
                s_axis_tvalid <= 1'b1;
                void'(pending_cmds.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk)
        m_axis_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);

    // level beat checker
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.status = status_t'(m_axis_tuser[1:0]);
            got.side_empty = m_axis_tuser[2];
            got.aid = m_axis_tdata[31:0];
            got.rank = m_axis_tdata[35:32];
            got.price = m_axis_tdata[55:36];
            got.orders = m_axis_tdata[62:56];
            got.quantity = m_axis_tdata[88:63];
            got.last = m_axis_tlast;
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = expected_levels.pop_front();
                if (got.status !== want.status || got.aid !== want.aid ||
                    got.side_empty !== want.side_empty || got.rank !== want.rank ||
                    got.price !== want.price || got.orders !== want.orders ||
                    got.quantity !== want.quantity || got.last !== want.last) begin
                    $display("%0t: level mismatch, expected %h, actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_levels.size() != 0);
        repeat (800) @(posedge aclk);
    endtask

    task automatic write_shown(logic [3:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        shown_reg = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sequence of phases
    initial begin
        int add_pct [PHASES] = '{75, 92, 30, 20, 60};
        int sell_pct [PHASES] = '{50, 85, 60, 50, 50};
        logic [3:0] shown_set [PHASES] = '{4'd15, 4'd10, 4'd1, 4'd0, 4'd5};
        for (int i = 0; i < BOOK_DEPTH; i++) begin
            book_valid[0][i] = 1'b0;
            book_valid[1][i] = 1'b0;
        end
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty sides, field extremes, hits and misses
        queue_cmd(make_cmd(OP_CANCEL, SIDE_BUY, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_BUY, 0, 1, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_BUY, 20'hFFFFF, 20'hFFFFF, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_BUY, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_BUY, 500, 7, 0));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_BUY, 0, 0, 1));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_BUY, 0, 0, 32'hFFFFFFFF));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_SELL, 0, 0, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_SELL, 20'hFFFFF, 1, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_SELL, 0, 20'hFFFFF, 0));
        queue_cmd(make_cmd(OP_ADD, SIDE_SELL, 0, 2, 0));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_SELL, 0, 0, 5));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_SELL, 0, 0, 0));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_SELL, 0, 0, 4));
        queue_cmd(make_cmd(OP_CANCEL, SIDE_SELL, 0, 0, 6));
        for (int i = 0; i < 12; i++)
            queue_cmd(make_cmd(OP_ADD, SIDE_BUY, 100 + i, 3 + i, 0));
        gen_ids = 19;
        wait_drained();

        // random phases with changing level count and idling
        for (int p = 0; p < PHASES; p++) begin
            write_shown(shown_set[p]);
            tx_idle_pct = (p < 2) ? 12 : (p < 4) ? 72 : 0;
            rx_idle_pct = (p < 2) ? 72 : (p < 4) ? 12 : 0;
            for (int i = 0; i < PHASE_LEN; i++) begin
                queue_cmd(random_cmd(add_pct[p], sell_pct[p]));
                if (pending_cmds[$].op == OP_ADD) gen_ids++;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // overall time limit
    initial begin
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/obpl_pkg.sv
rtl/obpl_front.sv
rtl/obpl_queue.sv
rtl/obpl_engine.sv
rtl/order_book_price_levels_top.sv
bench/tb_order_book_price_levels_top.sv
